FILE: sv/htc_pkg.sv
// htc_pkg: shared types and fixed constants of the heater thermostat controller.
// No dependencies; compiled first.
package htc_pkg;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_OP  = 2'd1,
        MODE_SET = 2'd2
    } mode_t;

    // configuration register file
    localparam int          ADDR_W    = 5;
    localparam logic [2:0]  REG_HYST  = 3'd0;
    localparam logic [2:0]  REG_STEP  = 3'd1;
    localparam logic [2:0]  REG_MIN   = 3'd2;
    localparam logic [2:0]  REG_MAX   = 3'd3;
    localparam logic [2:0]  REG_TOUT  = 3'd4;

    localparam logic [4:0]  HYST_RST  = 5'd5;
    localparam logic [4:0]  STEP_RST  = 5'd5;
    localparam logic [7:0]  MIN_RST   = 8'd35;
    localparam logic [7:0]  MAX_RST   = 8'd75;
    localparam logic [15:0] TOUT_RST  = 16'd1000;

    typedef struct packed {
        logic [4:0]  hysteresis;
        logic [4:0]  set_step;
        logic [7:0]  set_min;
        logic [7:0]  set_max;
        logic [15:0] set_timeout;
    } cfg_t;

    // controller constants
    localparam logic [7:0]  SETPOINT_RST = 8'd60;
    localparam int          DIGIT_W      = 4;
    localparam logic [3:0]  DIGIT_LAST   = 4'd9;   // digit phase runs 0..9
    localparam logic [3:0]  DIGIT_TENS   = 4'd5;
    localparam logic [3:0]  DIGIT_ONES   = 4'd0;
    localparam int          IDLE_W       = 17;
    localparam logic [16:0] IDLE_TOP     = 17'h1FFFF;

    // drive level bits
    localparam int DRV_HEATER = 0;
    localparam int DRV_COOLER = 1;
    localparam int DRV_LED    = 2;

endpackage

FILE: sv/htc_if.sv
// htc_if: valid/ready stream interfaces for tick items and result items.
// Depends on nothing; compiled after htc_pkg.
interface htc_in_if;
    logic       valid;
    logic       ready;
    logic       onoff_pressed;
    logic       up_pressed;
    logic       down_pressed;
    logic [7:0] temp_reading;

    modport source (output valid, onoff_pressed, up_pressed, down_pressed, temp_reading,
                    input ready);
    modport sink   (input valid, onoff_pressed, up_pressed, down_pressed, temp_reading,
                    output ready);
endinterface

interface htc_out_if;
    logic       valid;
    logic       ready;
    logic       heater_on;
    logic       cooler_on;
    logic       hot_led;
    logic       blink_pin;
    logic       disp_write;
    logic       disp_position;
    logic [4:0] disp_value;
    logic       disp_blank;
    logic [1:0] mode_now;

    modport source (output valid, heater_on, cooler_on, hot_led, blink_pin, disp_write,
                           disp_position, disp_value, disp_blank, mode_now,
                    input ready);
    modport sink   (input valid, heater_on, cooler_on, hot_led, blink_pin, disp_write,
                          disp_position, disp_value, disp_blank, mode_now,
                    output ready);
endinterface

FILE: sv/htc_regs.sv
// htc_regs: APB-style configuration registers of the thermostat controller.
// Depends on htc_pkg (cfg_t, register indexes, reset values).
module htc_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [htc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output htc_pkg::cfg_t             cfg
);

    htc_pkg::cfg_t cfg_reg;
    htc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                htc_pkg::REG_HYST: cfg_next.hysteresis  = pwdata[4:0];
                htc_pkg::REG_STEP: cfg_next.set_step    = pwdata[4:0];
                htc_pkg::REG_MIN:  cfg_next.set_min     = pwdata[7:0];
                htc_pkg::REG_MAX:  cfg_next.set_max     = pwdata[7:0];
                htc_pkg::REG_TOUT: cfg_next.set_timeout = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            htc_pkg::REG_HYST: prdata = {27'd0, cfg_reg.hysteresis};
            htc_pkg::REG_STEP: prdata = {27'd0, cfg_reg.set_step};
            htc_pkg::REG_MIN:  prdata = {24'd0, cfg_reg.set_min};
            htc_pkg::REG_MAX:  prdata = {24'd0, cfg_reg.set_max};
            htc_pkg::REG_TOUT: prdata = {16'd0, cfg_reg.set_timeout};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis  <= htc_pkg::HYST_RST;
            cfg_reg.set_step    <= htc_pkg::STEP_RST;
            cfg_reg.set_min     <= htc_pkg::MIN_RST;
            cfg_reg.set_max     <= htc_pkg::MAX_RST;
            cfg_reg.set_timeout <= htc_pkg::TOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/htc_avg.sv
// htc_avg: moving-average window of temperature samples, running sum and
// constant-reciprocal divide. No package dependency.
module htc_avg
#(
    parameter int WINDOW_LEN = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,      // sample enters the window this tick
    input  logic [7:0] temp,
    output logic [7:0] avg_now    // average after this tick's sample
);

    localparam int SUM_W  = $clog2(WINDOW_LEN * 255 + 1);
    localparam int DIV_SH = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = SUM_W + DIV_SH;
    // round-up reciprocal, exact for every sum below 2**SUM_W
    localparam logic [DIV_SH-1:0] DIV_MUL = DIV_SH'((1 << DIV_SH) / WINDOW_LEN + 1);

    logic [7:0]        win_reg [WINDOW_LEN];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [7:0]        avg_reg;
    logic [PROD_W-1:0] prod;
    logic [7:0]        quot;

    assign sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(temp);
    assign prod     = PROD_W'(sum_next) * PROD_W'(DIV_MUL);
    assign quot     = prod[DIV_SH +: 8];
    assign avg_now  = push ? quot : avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            sum_reg <= '0;
            avg_reg <= 8'd0;
        end
        else if (push)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WINDOW_LEN - 1] <= temp;
            sum_reg <= sum_next;
            avg_reg <= quot;
        end
    end

endmodule

FILE: sv/heater_thermostat_controller.sv
// heater_thermostat_controller: top level, tick processing, mode rules, result register.
// Depends on htc_pkg, htc_if (htc_in_if, htc_out_if), htc_regs and htc_avg.
//
//   port      kind          role     carries
//   in_ch     htc_in_if     sink     one tick: button presses and temperature reading
//   out_ch    htc_out_if    source   one result per tick: drives, blink, digit write, mode
//   psel..    APB           slave    configuration registers, 32-bit data
//
// One tick transaction is taken per clock while in_ch.ready is high; its result appears
// in the result register the cycle after acceptance, computed in a single pass from the
// state registers through the window sum, divide and mode rules to the result register.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Async reset (rst_n) sets all but the result payload at once; no clearing pass is needed.
module heater_thermostat_controller
#(
    parameter int WINDOW_LEN      = 10,
    parameter int SAMPLE_INTERVAL = 20,
    parameter int BLINK_PERIOD    = 200
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [htc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    htc_in_if.sink                     in_ch,
    htc_out_if.source                  out_ch
);

    localparam int PH_W = $clog2(BLINK_PERIOD);
    localparam int SP_W = (SAMPLE_INTERVAL > 1) ? $clog2(SAMPLE_INTERVAL) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(BLINK_PERIOD - 1);
    localparam logic [PH_W-1:0] PH_HALF = PH_W'(BLINK_PERIOD / 2);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(SAMPLE_INTERVAL - 1);

    typedef struct packed {
        logic       heater_on;
        logic       cooler_on;
        logic       hot_led;
        logic       blink_pin;
        logic       disp_write;
        logic       disp_position;
        logic [4:0] disp_value;
        logic       disp_blank;
        logic [1:0] mode_now;
    } res_t;

    // configuration
    htc_pkg::cfg_t cfg;

    // handshake
    logic in_acc;
    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;

    // controller state
    htc_pkg::mode_t              mode_reg, mode_next;
    logic [7:0]                  setpoint_reg, setpoint_next;
    logic [PH_W-1:0]             phase_reg, phase_next;
    logic [htc_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic [SP_W-1:0]             sample_reg, sample_next;
    logic [htc_pkg::IDLE_W-1:0]  timer_reg, timer_next;
    logic                        heating_reg, heating_next;
    logic [2:0]                  drive_reg, drive_next;
    logic                        blink_reg, blink_next;

    logic       push;
    logic [7:0] avg_now;

    htc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // free-running tick counters
    assign phase_next  = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
    assign digit_next  = (digit_reg == htc_pkg::DIGIT_LAST) ? '0 : digit_reg + 1'b1;
    assign sample_next = (sample_reg == SP_LAST) ? '0 : sample_reg + 1'b1;
    assign blink_next  = blink_reg ^ ((phase_next == '0) && heating_reg);
    assign push        = in_acc && (sample_next == '0);

    htc_avg #(.WINDOW_LEN(WINDOW_LEN)) u_avg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .temp    (in_ch.temp_reading),
        .avg_now (avg_now)
    );

    // handshake: result register parts the two sides
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [7:0]  shown;
        logic        show;
        logic [15:0] dig_prod;
        logic [4:0]  tens;
        logic [7:0]  ones;
        logic [7:0]  sp_dn;
        logic [8:0]  sp_up;

        mode_next     = mode_reg;
        setpoint_next = setpoint_reg;
        timer_next    = timer_reg;
        heating_next  = heating_reg;
        drive_next    = drive_reg;
        res_next      = '0;
        sp_dn         = setpoint_reg;
        sp_up         = '0;

        // display digits: temperature in operate, setpoint in set
        shown = in_ch.temp_reading;
        show  = 1'b1;
        if (mode_reg == htc_pkg::MODE_SET)
        begin
            shown = setpoint_reg;
            show  = phase_next < PH_HALF;
            if (timer_reg != htc_pkg::IDLE_TOP)
            begin
                timer_next = timer_reg + 1'b1;
            end
        end
        // divide by ten via reciprocal, exact for 8-bit values
        dig_prod = 16'(shown) * 16'd205;
        tens     = dig_prod[15:11];
        ones     = shown - {tens, 3'b000} - {2'b00, tens, 1'b0};

        if (mode_reg != htc_pkg::MODE_OFF && show)
        begin
            if (digit_next == htc_pkg::DIGIT_TENS)
            begin
                res_next.disp_write    = 1'b1;
                res_next.disp_position = 1'b0;
                res_next.disp_value    = tens;
            end
            else if (digit_next == htc_pkg::DIGIT_ONES)
            begin
                res_next.disp_write    = 1'b1;
                res_next.disp_position = 1'b1;
                res_next.disp_value    = {1'b0, ones[3:0]};
            end
        end
        res_next.disp_blank = (mode_reg == htc_pkg::MODE_SET) && !show;

        case (mode_reg)
            htc_pkg::MODE_OFF:
            begin
                drive_next = 3'b000;
                if (in_ch.onoff_pressed)
                begin
                    mode_next = htc_pkg::MODE_OP;
                end
            end
            htc_pkg::MODE_OP:
            begin
                if (in_ch.onoff_pressed)
                begin
                    mode_next    = htc_pkg::MODE_OFF;
                    heating_next = 1'b0;
                end
                if (in_ch.up_pressed || in_ch.down_pressed)
                begin
                    mode_next    = htc_pkg::MODE_SET;
                    timer_next   = '0;
                    heating_next = 1'b0;
                end
                // hysteresis still runs in the tick that leaves operate
                if (9'(avg_now) > 9'(setpoint_reg) + 9'(cfg.hysteresis))
                begin
                    drive_next[htc_pkg::DRV_HEATER] = 1'b0;
                    drive_next[htc_pkg::DRV_COOLER] = 1'b1;
                    drive_next[htc_pkg::DRV_LED]    = 1'b1;
                    heating_next = 1'b0;
                end
                if (9'(avg_now) + 9'(cfg.hysteresis) < 9'(setpoint_reg))
                begin
                    drive_next[htc_pkg::DRV_COOLER] = 1'b0;
                    drive_next[htc_pkg::DRV_HEATER] = 1'b1;
                    heating_next = 1'b1;
                end
            end
            htc_pkg::MODE_SET:
            begin
                drive_next = 3'b000;
                if (in_ch.onoff_pressed)
                begin
                    mode_next = htc_pkg::MODE_OFF;
                end
                // down first, then up; each clamped without wrap
                sp_dn = setpoint_reg;
                if (in_ch.down_pressed)
                begin
                    if (9'(setpoint_reg) < 9'(cfg.set_min) + 9'(cfg.set_step))
                    begin
                        sp_dn = cfg.set_min;
                    end
                    else
                    begin
                        sp_dn = setpoint_reg - 8'(cfg.set_step);
                    end
                    timer_next = '0;
                end
                sp_up         = 9'(sp_dn) + 9'(cfg.set_step);
                setpoint_next = sp_dn;
                if (in_ch.up_pressed)
                begin
                    setpoint_next = (sp_up > 9'(cfg.set_max)) ? cfg.set_max : sp_up[7:0];
                    timer_next    = '0;
                end
                // timeout wins over an on/off press
                if (timer_next > 17'(cfg.set_timeout))
                begin
                    timer_next = '0;
                    mode_next  = htc_pkg::MODE_OP;
                end
            end
            default:
            begin
                mode_next = htc_pkg::MODE_OFF;
            end
        endcase

        res_next.heater_on  = drive_next[htc_pkg::DRV_HEATER];
        res_next.cooler_on  = drive_next[htc_pkg::DRV_COOLER];
        res_next.hot_led    = drive_next[htc_pkg::DRV_LED];
        res_next.blink_pin  = blink_next;
        res_next.mode_now   = mode_next;
        if (mode_next == htc_pkg::MODE_OFF)
        begin
            res_next.disp_blank = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= htc_pkg::MODE_OFF;
            setpoint_reg  <= htc_pkg::SETPOINT_RST;
            phase_reg     <= '0;
            digit_reg     <= '0;
            sample_reg    <= '0;
            timer_reg     <= '0;
            heating_reg   <= 1'b0;
            drive_reg     <= 3'b000;
            blink_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg      <= mode_next;
                setpoint_reg  <= setpoint_next;
                phase_reg     <= phase_next;
                digit_reg     <= digit_next;
                sample_reg    <= sample_next;
                timer_reg     <= timer_next;
                heating_reg   <= heating_next;
                drive_reg     <= drive_next;
                blink_reg     <= blink_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.heater_on     = res_reg.heater_on;
    assign out_ch.cooler_on     = res_reg.cooler_on;
    assign out_ch.hot_led       = res_reg.hot_led;
    assign out_ch.blink_pin     = res_reg.blink_pin;
    assign out_ch.disp_write    = res_reg.disp_write;
    assign out_ch.disp_position = res_reg.disp_position;
    assign out_ch.disp_value    = res_reg.disp_value;
    assign out_ch.disp_blank    = res_reg.disp_blank;
    assign out_ch.mode_now      = res_reg.mode_now;

`ifndef SYNTH
    a_setpoint_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(setpoint_reg))
        else $error("setpoint changed without a tick transaction");

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(drive_reg[htc_pkg::DRV_HEATER] && drive_reg[htc_pkg::DRV_COOLER]))
        else $error("heater and cooler driven together");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg && (res_reg.mode_now == mode_reg))
        else $error("result register out of step with state");

    a_off_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.mode_now == htc_pkg::MODE_OFF) |-> res_reg.disp_blank)
        else $error("display not blanked in off mode");
`endif

endmodule
